// ===== rtl/rlmsd_pkg.sv =====
// Shared types, constants and codes for the LED matrix scan driver.
package rlmsd_pkg;

    // Panel geometry and color depth.
    localparam int ROWS       = 16;
    localparam int COLUMNS    = 32;
    localparam int COLOR_BITS = 3;

    // Derived sizes.
    localparam int HALF_ROWS  = ROWS / 2;
    localparam int HALF_DEPTH = HALF_ROWS * COLUMNS;
    localparam int ADDR_W     = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
    localparam int PAIR_W     = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Fixed field widths of the ports.
    localparam int CMD_W     = 2;
    localparam int FIELD_W   = 8;
    localparam int STATUS_W  = 2;
    localparam int ROWSEL_W  = 3;
    localparam int TICKS_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Register reset values.
    localparam logic [TICKS_W-1:0] ROW_ON_RESET    = TICKS_W'(500);
    localparam logic [TICKS_W-1:0] FRAME_GAP_RESET = TICKS_W'(0);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ON    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP = CFG_IDX_W'(1);

    // Command codes of an input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // Status codes of a result transaction.
    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_BAD_POS   = 2'd1,
        STS_BAD_COLOR = 2'd2
    } t_status;

    // Scan sequence phases.
    typedef enum logic [2:0] {
        PH_BLANK      = 3'd0,
        PH_CLK_HIGH   = 3'd1,
        PH_CLK_LOW    = 3'd2,
        PH_LATCH_HIGH = 3'd3,
        PH_LATCH_LOW  = 3'd4,
        PH_ON         = 3'd5,
        PH_GAP        = 3'd6
    } t_phase;

    // Controller states.
    typedef enum logic [1:0] {
        CS_SWEEP = 2'd0,
        CS_IDLE  = 2'd1,
        CS_FETCH = 2'd2
    } t_ctrl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;  // a transaction is taken this cycle
        logic tick;    // advance the scan by one step (not the clock-high step)
        logic load;    // finish the clock-high step from the frame store read
        logic sweep;   // write zero at the sweep address of both frame store halves
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clk_high;    // scan is at the clock-high phase
        logic sweep_last;  // clearing sweep is at its last address
    } t_dp_stat;

endpackage

// ===== rtl/rlmsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rlmsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rlmsd_ctrl.sv =====
// Controller state machine: transaction acceptance, clearing sweep and result strobe.
module rlmsd_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rlmsd_pkg::CMD_W-1:0]    i_cmd,
    input  rlmsd_pkg::t_dp_stat            i_stat,
    output rlmsd_pkg::t_dp_cmd             o_cmd,
    output logic                           o_busy,
    output logic                           o_done
);

    rlmsd_pkg::t_ctrl_state r_state;
    rlmsd_pkg::t_ctrl_state n_state;
    logic                   r_done;
    logic                   n_done;

    // State and strobe registers; reset starts with a clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rlmsd_pkg::CS_SWEEP;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state      = r_state;
        n_done       = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            rlmsd_pkg::CS_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = rlmsd_pkg::CS_IDLE;
                end
            end
            rlmsd_pkg::CS_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    unique case (rlmsd_pkg::t_cmd'(i_cmd))
                        rlmsd_pkg::CMD_CLEAR: begin
                            n_done  = 1'b1;
                            n_state = rlmsd_pkg::CS_SWEEP;
                        end
                        rlmsd_pkg::CMD_TICK: begin
                            if (i_stat.clk_high) begin
                                n_state = rlmsd_pkg::CS_FETCH;
                            end else begin
                                o_cmd.tick = 1'b1;
                                n_done     = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            rlmsd_pkg::CS_FETCH: begin
                o_cmd.load = 1'b1;
                n_done     = 1'b1;
                n_state    = rlmsd_pkg::CS_IDLE;
            end
            default: begin
                n_state = rlmsd_pkg::CS_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != rlmsd_pkg::CS_IDLE);
    assign o_done = r_done;

endmodule

// ===== rtl/rlmsd_datapath.sv =====
// Datapath: frame store, pixel checks, scan sequence registers and pin levels.
module rlmsd_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rlmsd_pkg::t_dp_cmd                  i_cmd,
    input  logic [rlmsd_pkg::CMD_W-1:0]         i_op,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_row,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_column,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_color,
    input  logic                                i_cfg_we,
    input  logic [rlmsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rlmsd_pkg::TICKS_W-1:0]       i_cfg_wdata,
    output rlmsd_pkg::t_dp_stat                 o_stat,
    output logic [rlmsd_pkg::STATUS_W-1:0]      o_status,
    output logic                                o_output_disable,
    output logic [rlmsd_pkg::ROWSEL_W-1:0]      o_row_select,
    output logic [rlmsd_pkg::COLOR_BITS-1:0]    o_rgb_top,
    output logic [rlmsd_pkg::COLOR_BITS-1:0]    o_rgb_bottom,
    output logic                                o_shift_clock,
    output logic                                o_latch
);

    localparam int AW = rlmsd_pkg::ADDR_W;
    localparam int CB = rlmsd_pkg::COLOR_BITS;

    // Configuration registers.
    logic [rlmsd_pkg::TICKS_W-1:0] r_row_on;
    logic [rlmsd_pkg::TICKS_W-1:0] r_frame_gap;

    // Scan state.
    rlmsd_pkg::t_phase             r_phase, n_phase;
    logic [rlmsd_pkg::PAIR_W-1:0]  r_pair, n_pair;
    logic [rlmsd_pkg::COL_W-1:0]   r_col, n_col;
    logic [rlmsd_pkg::TICKS_W-1:0] r_wait, n_wait;
    logic [rlmsd_pkg::TICKS_W-1:0] wait_dec;

    // Pin levels and status.
    logic                             r_oe, n_oe;
    logic [rlmsd_pkg::ROWSEL_W-1:0]   r_row, n_row;
    logic [CB-1:0]                    r_top, n_top;
    logic [CB-1:0]                    r_bot, n_bot;
    logic                             r_clk, n_clk;
    logic                             r_lat, n_lat;
    logic [rlmsd_pkg::STATUS_W-1:0]   r_status;

    // Clearing sweep counter.
    logic [AW-1:0] r_sweep;
    logic          sweep_last;

    // Pixel write checks and addressing.
    logic                          bad_pos;
    logic                          bad_color;
    rlmsd_pkg::t_status            wr_status;
    logic                          is_write;
    logic                          wr_ok;
    logic                          wr_bottom;
    logic [rlmsd_pkg::FIELD_W-1:0] row_in_half;
    logic [AW-1:0]                 wr_addr;
    logic [AW-1:0]                 rd_addr;
    logic                          we_top;
    logic                          we_bot;
    logic [AW-1:0]                 waddr;
    logic [CB-1:0]                 wdata;
    logic [CB-1:0]                 rdata_top;
    logic [CB-1:0]                 rdata_bot;

    // Position is checked before color.
    assign bad_pos   = (i_pixel_row >= rlmsd_pkg::FIELD_W'(rlmsd_pkg::ROWS)) ||
                       (i_pixel_column >= rlmsd_pkg::FIELD_W'(rlmsd_pkg::COLUMNS));
    assign bad_color = ((9'(i_pixel_color) >> CB) != 9'd0);
    assign wr_status = bad_pos   ? rlmsd_pkg::STS_BAD_POS :
                       bad_color ? rlmsd_pkg::STS_BAD_COLOR : rlmsd_pkg::STS_OK;
    assign is_write  = (rlmsd_pkg::t_cmd'(i_op) == rlmsd_pkg::CMD_WRITE);
    assign wr_ok     = i_cmd.accept && is_write && !bad_pos && !bad_color;

    // Rows of the upper half go to one store, rows of the lower half to the other.
    assign wr_bottom   = (i_pixel_row >= rlmsd_pkg::FIELD_W'(rlmsd_pkg::HALF_ROWS));
    assign row_in_half = wr_bottom ?
                         (i_pixel_row - rlmsd_pkg::FIELD_W'(rlmsd_pkg::HALF_ROWS)) :
                         i_pixel_row;
    assign wr_addr = AW'(row_in_half) * AW'(rlmsd_pkg::COLUMNS) + AW'(i_pixel_column);
    assign rd_addr = AW'(r_pair) * AW'(rlmsd_pkg::COLUMNS) + AW'(r_col);

    // The sweep writes zero to the same address in both halves.
    assign we_top = i_cmd.sweep || (wr_ok && !wr_bottom);
    assign we_bot = i_cmd.sweep || (wr_ok && wr_bottom);
    assign waddr  = i_cmd.sweep ? r_sweep : wr_addr;
    assign wdata  = i_cmd.sweep ? '0 : CB'(i_pixel_color);

    rlmsd_ram #(
        .WIDTH (CB),
        .DEPTH (rlmsd_pkg::HALF_DEPTH)
    ) u_store_top (
        .i_clk   (i_clk),
        .i_we    (we_top),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata_top)
    );

    rlmsd_ram #(
        .WIDTH (CB),
        .DEPTH (rlmsd_pkg::HALF_DEPTH)
    ) u_store_bot (
        .i_clk   (i_clk),
        .i_we    (we_bot),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata_bot)
    );

    assign sweep_last = (r_sweep == AW'(rlmsd_pkg::HALF_DEPTH - 1));
    assign wait_dec   = (r_wait != '0) ? (r_wait - 1'b1) : r_wait;

    // One step of the scan sequence.
    always_comb begin
        n_phase = r_phase;
        n_pair  = r_pair;
        n_col   = r_col;
        n_wait  = r_wait;
        n_oe    = r_oe;
        n_row   = r_row;
        n_top   = r_top;
        n_bot   = r_bot;
        n_clk   = r_clk;
        n_lat   = r_lat;
        if (i_cmd.load) begin
            n_top   = rdata_top;
            n_bot   = rdata_bot;
            n_clk   = 1'b1;
            n_phase = rlmsd_pkg::PH_CLK_LOW;
        end else if (i_cmd.tick) begin
            unique case (r_phase)
                rlmsd_pkg::PH_BLANK: begin
                    n_oe    = 1'b1;
                    n_row   = rlmsd_pkg::ROWSEL_W'(r_pair);
                    n_col   = '0;
                    n_phase = rlmsd_pkg::PH_CLK_HIGH;
                end
                rlmsd_pkg::PH_CLK_LOW: begin
                    n_clk = 1'b0;
                    if (r_col == rlmsd_pkg::COL_W'(rlmsd_pkg::COLUMNS - 1)) begin
                        n_col   = '0;
                        n_phase = rlmsd_pkg::PH_LATCH_HIGH;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_phase = rlmsd_pkg::PH_CLK_HIGH;
                    end
                end
                rlmsd_pkg::PH_LATCH_HIGH: begin
                    n_lat   = 1'b1;
                    n_phase = rlmsd_pkg::PH_LATCH_LOW;
                end
                rlmsd_pkg::PH_LATCH_LOW: begin
                    n_lat = 1'b0;
                    n_oe  = 1'b0;
                    if (r_row_on != '0) begin
                        n_wait  = r_row_on;
                        n_phase = rlmsd_pkg::PH_ON;
                    end
                end
                rlmsd_pkg::PH_ON: begin
                    n_wait = wait_dec;
                end
                rlmsd_pkg::PH_GAP: begin
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        n_phase = rlmsd_pkg::PH_BLANK;
                    end
                end
                default: begin
                    n_phase = rlmsd_pkg::PH_BLANK;
                end
            endcase
            // End of a lit row pair: next pair, or the frame gap after the last.
            if ((r_phase == rlmsd_pkg::PH_LATCH_LOW && r_row_on == '0) ||
                (r_phase == rlmsd_pkg::PH_ON && wait_dec == '0)) begin
                if (r_pair == rlmsd_pkg::PAIR_W'(rlmsd_pkg::HALF_ROWS - 1)) begin
                    n_pair = '0;
                    if (r_frame_gap == '0) begin
                        n_phase = rlmsd_pkg::PH_BLANK;
                    end else begin
                        n_wait  = r_frame_gap;
                        n_phase = rlmsd_pkg::PH_GAP;
                    end
                end else begin
                    n_pair  = r_pair + 1'b1;
                    n_phase = rlmsd_pkg::PH_BLANK;
                end
            end
        end
    end

    // Configuration, scan state, pins, status and sweep registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_on    <= rlmsd_pkg::ROW_ON_RESET;
            r_frame_gap <= rlmsd_pkg::FRAME_GAP_RESET;
            r_phase     <= rlmsd_pkg::PH_BLANK;
            r_pair      <= '0;
            r_col       <= '0;
            r_wait      <= '0;
            r_oe        <= 1'b1;
            r_row       <= '0;
            r_top       <= '0;
            r_bot       <= '0;
            r_clk       <= 1'b0;
            r_lat       <= 1'b0;
            r_status    <= rlmsd_pkg::STS_OK;
            r_sweep     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rlmsd_pkg::CFG_ROW_ON) begin
                    r_row_on <= i_cfg_wdata;
                end
                if (i_cfg_index == rlmsd_pkg::CFG_FRAME_GAP) begin
                    r_frame_gap <= i_cfg_wdata;
                end
            end
            r_phase <= n_phase;
            r_pair  <= n_pair;
            r_col   <= n_col;
            r_wait  <= n_wait;
            r_oe    <= n_oe;
            r_row   <= n_row;
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_clk   <= n_clk;
            r_lat   <= n_lat;
            if (i_cmd.accept) begin
                r_status <= is_write ? wr_status : rlmsd_pkg::STS_OK;
            end
            if (i_cmd.sweep) begin
                r_sweep <= sweep_last ? '0 : (r_sweep + 1'b1);
            end
        end
    end

    assign o_stat.clk_high   = (r_phase == rlmsd_pkg::PH_CLK_HIGH);
    assign o_stat.sweep_last = sweep_last;

    assign o_status         = r_status;
    assign o_output_disable = r_oe;
    assign o_row_select     = r_row;
    assign o_rgb_top        = r_top;
    assign o_rgb_bottom     = r_bot;
    assign o_shift_clock    = r_clk;
    assign o_latch          = r_lat;

endmodule

// ===== rtl/rgb_led_matrix_scan_driver_unit.sv =====
// Top level of the LED matrix scan driver: controller and datapath.
//
// A transaction is taken when start is high and busy is low; its result shows on the
// output ports for one cycle with o_done high, and the receiver cannot stall it. A pixel
// write, a scan tick and an unused command give their result in the cycle after
// acceptance and leave the block free for the next transaction in that same cycle. A
// scan tick at the clock-high step passes through a fetch state first, since the frame
// store has a registered read port. A clear acknowledges in the cycle after acceptance
// and then keeps busy high while it writes zero into all HALF_ROWS*COLUMNS (256)
// addresses of both frame store halves, one address per cycle. After reset the same
// clearing pass runs before the first transaction is taken. Configuration writes are
// taken at any time and do not wait. The pin outputs hold their levels between results.
module rgb_led_matrix_scan_driver_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rlmsd_pkg::CMD_W-1:0]         i_cmd,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_row,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_column,
    input  logic [rlmsd_pkg::FIELD_W-1:0]       i_pixel_color,
    input  logic                                i_cfg_we,
    input  logic [rlmsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rlmsd_pkg::TICKS_W-1:0]       i_cfg_wdata,
    output logic                                o_done,
    output logic [rlmsd_pkg::STATUS_W-1:0]      o_status,
    output logic                                o_output_disable,
    output logic [rlmsd_pkg::ROWSEL_W-1:0]      o_row_select,
    output logic [rlmsd_pkg::COLOR_BITS-1:0]    o_rgb_top,
    output logic [rlmsd_pkg::COLOR_BITS-1:0]    o_rgb_bottom,
    output logic                                o_shift_clock,
    output logic                                o_latch
);

    rlmsd_pkg::t_dp_cmd  dp_cmd;
    rlmsd_pkg::t_dp_stat dp_stat;

    // Transaction sequencing.
    rlmsd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Frame store and scan sequence.
    rlmsd_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_op             (i_cmd),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_column   (i_pixel_column),
        .i_pixel_color    (i_pixel_color),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_stat           (dp_stat),
        .o_status         (o_status),
        .o_output_disable (o_output_disable),
        .o_row_select     (o_row_select),
        .o_rgb_top        (o_rgb_top),
        .o_rgb_bottom     (o_rgb_bottom),
        .o_shift_clock    (o_shift_clock),
        .o_latch          (o_latch)
    );

endmodule

// ===== verif/rgb_led_matrix_scan_driver_unit_test.sv =====
// Self-checking testbench for the LED matrix scan driver, with a built-in pin-level predictor.
`timescale 1ns / 1ps

module rgb_led_matrix_scan_driver_unit_test;
    import rlmsd_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 6;

    // One input transaction.
    typedef struct packed {
        t_cmd               cmd;
        logic [FIELD_W-1:0] row;
        logic [FIELD_W-1:0] col;
        logic [FIELD_W-1:0] color;
    } t_item;

    // Status and panel pin levels of one result transaction.
    typedef struct packed {
        t_status               status;
        logic                  oe;
        logic [ROWSEL_W-1:0]   row_sel;
        logic [COLOR_BITS-1:0] top;
        logic [COLOR_BITS-1:0] bottom;
        logic                  clk;
        logic                  lat;
    } t_panel;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 start          = 1'b0;
    logic [CMD_W-1:0]     i_cmd          = '0;
    logic [FIELD_W-1:0]   i_pixel_row    = '0;
    logic [FIELD_W-1:0]   i_pixel_column = '0;
    logic [FIELD_W-1:0]   i_pixel_color  = '0;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [TICKS_W-1:0]   i_cfg_wdata    = '0;
    logic                 busy;
    logic                 o_done;
    logic [STATUS_W-1:0]  o_status;
    logic                 o_output_disable;
    logic [ROWSEL_W-1:0]  o_row_select;
    logic [COLOR_BITS-1:0] o_rgb_top;
    logic [COLOR_BITS-1:0] o_rgb_bottom;
    logic                 o_shift_clock;
    logic                 o_latch;

    rgb_led_matrix_scan_driver_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_pixel_row      (i_pixel_row),
        .i_pixel_column   (i_pixel_column),
        .i_pixel_color    (i_pixel_color),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_output_disable (o_output_disable),
        .o_row_select     (o_row_select),
        .o_rgb_top        (o_rgb_top),
        .o_rgb_bottom     (o_rgb_bottom),
        .o_shift_clock    (o_shift_clock),
        .o_latch          (o_latch)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transactions waiting to be sent and panel results still to arrive.
    t_item  cmd_queue[$];
    t_panel panel_due[$];
    int     fault_count = 0;
    logic   item_taken  = 1'b0;

    // Predictor state: frame store, scan position, wait counter, registers and pins.
    logic [COLOR_BITS-1:0] px_mem[ROWS*COLUMNS];
    int                    cur_pair;
    int                    cur_col;
    t_phase                cur_phase;
    logic [TICKS_W-1:0]    dwell_cnt;
    logic [TICKS_W-1:0]    lit_ticks;
    logic [TICKS_W-1:0]    gap_ticks;
    t_panel                pin_state;

    function automatic t_item make_item(t_cmd c, int r, int col, int color);
        t_item it;
        it.cmd   = c;
        it.row   = FIELD_W'(r);
        it.col   = FIELD_W'(col);
        it.color = FIELD_W'(color);
        return it;
    endfunction

    // Random transaction: mostly scan ticks and well-formed writes, some bad writes,
    // a few clears and unused commands.
    function automatic t_item random_item();
        int    pick;
        t_item it;
        pick = $urandom_range(0, 99);
        it   = make_item(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 255));
        if (pick >= 62 && pick < 92) begin
            it.cmd = CMD_WRITE;
            if ($urandom_range(0, 4) != 0) begin
                it.row   = FIELD_W'($urandom_range(0, ROWS - 1));
                it.col   = FIELD_W'($urandom_range(0, COLUMNS - 1));
                it.color = ($urandom_range(0, 9) == 0) ? FIELD_W'($urandom_range(8, 255))
                                                       : FIELD_W'($urandom_range(0, 7));
            end
        end else if (pick >= 92 && pick < 94) begin
            it.cmd = CMD_CLEAR;
        end else if (pick >= 94) begin
            it.cmd = CMD_NONE;
        end
        return it;
    endfunction

    // Leave the current row pair: next pair, or the frame gap after the last one.
    task automatic finish_row_pair();
        cur_pair++;
        if (cur_pair >= HALF_ROWS) begin
            cur_pair = 0;
            if (gap_ticks == 0) begin
                cur_phase = PH_BLANK;
            end else begin
                dwell_cnt = gap_ticks;
                cur_phase = PH_GAP;
            end
        end else begin
            cur_phase = PH_BLANK;
        end
    endtask

    // One step of the scan sequence.
    task automatic advance_scan();
        int r;
        int c;
        r = cur_pair % HALF_ROWS;
        c = cur_col % COLUMNS;
        case (cur_phase)
            PH_BLANK: begin
                pin_state.oe      = 1'b1;
                pin_state.row_sel = ROWSEL_W'(r);
                cur_col           = 0;
                cur_phase         = PH_CLK_HIGH;
            end
            PH_CLK_HIGH: begin
                pin_state.top    = px_mem[r * COLUMNS + c];
                pin_state.bottom = px_mem[(r + HALF_ROWS) * COLUMNS + c];
                pin_state.clk    = 1'b1;
                cur_phase        = PH_CLK_LOW;
            end
            PH_CLK_LOW: begin
                pin_state.clk = 1'b0;
                cur_col       = c + 1;
                cur_phase     = (cur_col >= COLUMNS) ? PH_LATCH_HIGH : PH_CLK_HIGH;
            end
            PH_LATCH_HIGH: begin
                pin_state.lat = 1'b1;
                cur_phase     = PH_LATCH_LOW;
            end
            PH_LATCH_LOW: begin
                pin_state.lat = 1'b0;
                pin_state.oe  = 1'b0;
                // With no lit time the row pair ends on this very tick.
                if (lit_ticks == 0) begin
                    finish_row_pair();
                end else begin
                    dwell_cnt = lit_ticks;
                    cur_phase = PH_ON;
                end
            end
            PH_ON: begin
                if (dwell_cnt > 0) dwell_cnt--;
                if (dwell_cnt == 0) finish_row_pair();
            end
            PH_GAP: begin
                if (dwell_cnt > 0) dwell_cnt--;
                if (dwell_cnt == 0) cur_phase = PH_BLANK;
            end
            default: begin
                cur_phase = PH_BLANK;
            end
        endcase
    endtask

    // Work out the result of one accepted transaction and update the predictor.
    task automatic predict_panel(input t_item it, output t_panel res);
        t_status st;
        st = STS_OK;
        case (it.cmd)
            CMD_WRITE: begin
                if (it.row > ROWS - 1 || it.col > COLUMNS - 1) begin
                    st = STS_BAD_POS;
                end else if (it.color > (1 << COLOR_BITS) - 1) begin
                    st = STS_BAD_COLOR;
                end else begin
                    px_mem[it.row * COLUMNS + it.col] = it.color[COLOR_BITS-1:0];
                end
            end
            CMD_CLEAR: begin
                foreach (px_mem[i]) px_mem[i] = '0;
            end
            CMD_TICK: begin
                advance_scan();
            end
            default: begin
            end
        endcase
        res        = pin_state;
        res.status = st;
    endtask

    task automatic log_fault(input string what, input t_panel want, input t_panel got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%0t %s", $realtime, what);
            $display("  expected status=%0d oe=%0b row=%0d top=%0d bottom=%0d clk=%0b lat=%0b",
                     want.status, want.oe, want.row_sel, want.top, want.bottom, want.clk,
                     want.lat);
            $display("  actual   status=%0d oe=%0b row=%0d top=%0d bottom=%0d clk=%0b lat=%0b",
                     got.status, got.oe, got.row_sel, got.top, got.bottom, got.clk, got.lat);
        end
    endtask

    // Record whether a transaction was taken at this edge.
    always @(posedge i_clk) begin
        item_taken <= i_rst_n && start && !busy;
    end

    // Driver: sends queued transactions in bursts with random gaps, and now and then
    // holds off until every outstanding result has come back.
    int   burst_left = 8;
    int   gap_left   = 0;
    logic drain_hold = 1'b0;

    always @(negedge i_clk) begin : cmd_driver
        t_panel res;
        t_item  head;
        if (item_taken) begin
            predict_panel(cmd_queue.pop_front(), res);
            panel_due.push_back(res);
            burst_left--;
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            if ($urandom_range(0, 99) == 0) drain_hold = 1'b1;
        end
        if (drain_hold && panel_due.size() == 0) drain_hold = 1'b0;
        if (gap_left == 0 && !drain_hold && cmd_queue.size() > 0) begin
            head = cmd_queue[0];
            start          <= 1'b1;
            i_cmd          <= head.cmd;
            i_pixel_row    <= head.row;
            i_pixel_column <= head.col;
            i_pixel_color  <= head.color;
        end else begin
            if (gap_left > 0) gap_left--;
            start          <= 1'b0;
            i_cmd          <= CMD_W'($urandom_range(0, 3));
            i_pixel_row    <= FIELD_W'($urandom_range(0, 255));
            i_pixel_column <= FIELD_W'($urandom_range(0, 255));
            i_pixel_color  <= FIELD_W'($urandom_range(0, 255));
        end
    end

    // Monitor: each strobed result is checked against the oldest expected one.
    always @(posedge i_clk) begin : result_monitor
        t_panel got;
        t_panel want;
        if (i_rst_n && o_done) begin
            got.status  = t_status'(o_status);
            got.oe      = o_output_disable;
            got.row_sel = o_row_select;
            got.top     = o_rgb_top;
            got.bottom  = o_rgb_bottom;
            got.clk     = o_shift_clock;
            got.lat     = o_latch;
            if (panel_due.size() == 0) begin
                log_fault("result with no transaction outstanding", '0, got);
            end else begin
                want = panel_due.pop_front();
                if (got.status !== want.status || got.oe !== want.oe ||
                    got.row_sel !== want.row_sel || got.top !== want.top ||
                    got.bottom !== want.bottom || got.clk !== want.clk ||
                    got.lat !== want.lat) begin
                    log_fault("result mismatch", want, got);
                end
            end
        end
    end

    // Watchdog on cycles without an accepted transaction.
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Wait until nothing is queued or outstanding and the block is free.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || panel_due.size() != 0 || start || busy);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers; the block is idle, so the predictor follows at once.
    task automatic apply_config(input logic [TICKS_W-1:0] on_ticks,
                                input logic [TICKS_W-1:0] idle_ticks);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROW_ON;
        i_cfg_wdata <= on_ticks;
        lit_ticks = on_ticks;
        @(negedge i_clk);
        i_cfg_index <= CFG_FRAME_GAP;
        i_cfg_wdata <= idle_ticks;
        gap_ticks = idle_ticks;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus: reset, a directed part with the reset settings, then random phases.
    initial begin
        int unsigned on_list[PHASES];
        int unsigned gap_list[PHASES];
        int          count_list[PHASES];

        on_list    = '{0, 1, 2, 0, 4, 65535};
        gap_list   = '{0, 1, 0, 5, 3, 65535};
        count_list = '{260, 260, 260, 260, 260, 120};

        foreach (px_mem[i]) px_mem[i] = '0;
        cur_pair  = 0;
        cur_col   = 0;
        cur_phase = PH_BLANK;
        dwell_cnt = '0;
        lit_ticks = ROW_ON_RESET;
        gap_ticks = FRAME_GAP_RESET;
        pin_state = '0;
        pin_state.oe = 1'b1;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Corners of the frame, bad position, bad color and both together.
        cmd_queue.push_back(make_item(CMD_WRITE, 0, 0, 7));
        cmd_queue.push_back(make_item(CMD_WRITE, 8, 0, 2));
        cmd_queue.push_back(make_item(CMD_WRITE, 15, 31, 7));
        cmd_queue.push_back(make_item(CMD_WRITE, 16, 0, 1));
        cmd_queue.push_back(make_item(CMD_WRITE, 0, 32, 1));
        cmd_queue.push_back(make_item(CMD_WRITE, 255, 255, 255));
        cmd_queue.push_back(make_item(CMD_WRITE, 3, 4, 8));
        cmd_queue.push_back(make_item(CMD_WRITE, 0, 0, 255));
        cmd_queue.push_back(make_item(CMD_NONE, 170, 85, 255));
        // Shift the first columns out, then clear mid-row and keep shifting.
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_TICK, 255, 255, 255));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_CLEAR, 255, 255, 255));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_WRITE, 0, 2, 6));
        cmd_queue.push_back(make_item(CMD_WRITE, 15, 31, 0));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_TICK, 0, 0, 0));
        cmd_queue.push_back(make_item(CMD_NONE, 0, 0, 0));
        wait_idle();

        // Random phases, each under its own register setting, extremes last.
        for (int p = 0; p < PHASES; p++) begin
            apply_config(TICKS_W'(on_list[p]), TICKS_W'(gap_list[p]));
            for (int k = 0; k < count_list[p]; k++) cmd_queue.push_back(random_item());
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (panel_due.size() != 0) fault_count++;
        if (fault_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
